>>> rtl/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// Shared constants, opcodes and control types for the cheat code interpreter.
// ----------------------------------------------------------------------------
package cci_pkg;

  // Configuration of the engine
  localparam int MAX_SERIAL_WRITES = 64;
  localparam int ADDRESS_BITS      = 24;

  // Field widths
  localparam int OPC_W  = 8;
  localparam int ADDR_W = 24;
  localparam int WADR_W = 25;
  localparam int DATA_W = 16;
  localparam int STEP_W = 8;

  // Serial count and index width: must hold MAX_SERIAL_WRITES itself
  localparam int CNT_W = $clog2(MAX_SERIAL_WRITES + 1);

  // Address mask applied to incoming line addresses
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  // Opcodes
  localparam logic [OPC_W-1:0] OP_WR_BYTE     = 8'h80;
  localparam logic [OPC_W-1:0] OP_WR_BYTE_ALT = 8'hA0;
  localparam logic [OPC_W-1:0] OP_WR_HALF     = 8'h81;
  localparam logic [OPC_W-1:0] OP_WR_HALF_ALT = 8'hA1;
  localparam logic [OPC_W-1:0] OP_BTN_BYTE    = 8'h88;
  localparam logic [OPC_W-1:0] OP_BTN_HALF    = 8'h89;
  localparam logic [OPC_W-1:0] OP_EQ_BYTE     = 8'hD0;
  localparam logic [OPC_W-1:0] OP_EQ_HALF     = 8'hD1;
  localparam logic [OPC_W-1:0] OP_NE_BYTE     = 8'hD2;
  localparam logic [OPC_W-1:0] OP_NE_HALF     = 8'hD3;
  localparam logic [OPC_W-1:0] OP_SERIAL      = 8'h50;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // take the offered request this cycle
    logic run_step;  // emit the next serial write into the output register
  } cci_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_free; // output register empty or being taken
    logic run_go;    // offered request starts a serial run
    logic run_last;  // current serial write is the final one
  } cci_status_t;

endpackage

>>> rtl/cci_ctrl.sv
// ----------------------------------------------------------------------------
// cci_ctrl
// Sequencer: takes code lines; serial runs emit one write per unstalled cycle.
// ----------------------------------------------------------------------------
module cci_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cci_pkg::cci_status_t status,
  output cci_pkg::cci_cmd_t    cmd
);
  import cci_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  // Decode commands and next state
  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.run_step = 1'b0;
    in_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall   = !status.slot_free;
        cmd.accept = in_valid && status.slot_free;
        if (cmd.accept && status.run_go) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run_step = status.slot_free;
        if (status.slot_free && status.run_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/cci_datapath.sv
// ----------------------------------------------------------------------------
// cci_datapath
// Cheat state, line decode, serial run counters and the output register.
// ----------------------------------------------------------------------------
module cci_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cci_pkg::cci_cmd_t           cmd,
  output cci_pkg::cci_status_t        status,
  input  logic                        first_in_cheat,
  input  logic                        cheat_active,
  input  logic [cci_pkg::OPC_W-1:0]   opcode,
  input  logic [cci_pkg::ADDR_W-1:0]  target_address,
  input  logic [cci_pkg::DATA_W-1:0]  operand_value,
  input  logic [cci_pkg::DATA_W-1:0]  memory_value,
  input  logic                        button_pressed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        write_valid,
  output logic [cci_pkg::WADR_W-1:0]  write_address,
  output logic [cci_pkg::DATA_W-1:0]  write_data,
  output logic                        write_halfword,
  output logic                        illegal_code,
  output logic                        last_result
);
  import cci_pkg::*;

  // Cheat state
  logic              execute_enabled, execute_enabled_next;
  logic              serial_pending,  serial_pending_next;
  logic [CNT_W-1:0]  run_len,         run_len_next;
  logic [STEP_W-1:0] addr_step,       addr_step_next;
  logic [DATA_W-1:0] value_step,      value_step_next;
  logic              cheat_rejected,  cheat_rejected_next;

  // Serial run
  logic [WADR_W-1:0] run_addr;
  logic [7:0]        run_data;
  logic [CNT_W-1:0]  run_idx;

  // Effective state after the first-line clear
  logic              ex_eff, pend_eff, rej_eff;
  logic [ADDR_W-1:0] addr_m;
  logic [7:0]        hdr_count;
  logic              skip_first;

  // Single result of a line
  logic              res_wv, res_half, res_illegal;

  assign ex_eff    = execute_enabled || first_in_cheat;
  assign pend_eff  = serial_pending && !first_in_cheat;
  assign rej_eff   = cheat_rejected && !first_in_cheat;
  assign addr_m    = target_address & ADDR_MASK;
  assign hdr_count = addr_m[15:8];
  assign skip_first = !ex_eff;

  assign status.slot_free = !out_valid || !out_stall;
  assign status.run_last  = (run_idx == run_len - CNT_W'(1));
  assign status.run_go    = !rej_eff && pend_eff && cheat_active &&
                            ((run_len > CNT_W'(1)) ||
                             ((run_len == CNT_W'(1)) && ex_eff));

  // Decode the offered line
  always_comb begin
    execute_enabled_next = execute_enabled;
    serial_pending_next  = serial_pending;
    run_len_next         = run_len;
    addr_step_next       = addr_step;
    value_step_next      = value_step;
    cheat_rejected_next  = cheat_rejected;
    res_wv               = 1'b0;
    res_half             = 1'b0;
    res_illegal          = 1'b0;
    if (cmd.accept) begin
      execute_enabled_next = ex_eff;
      serial_pending_next  = pend_eff;
      cheat_rejected_next  = rej_eff;
      if (rej_eff) begin
        // muted until the next first line
      end else if (pend_eff) begin
        serial_pending_next = 1'b0;
        if (run_len != '0) begin
          execute_enabled_next = 1'b1;
        end
      end else begin
        case (opcode)
          OP_WR_BYTE, OP_WR_BYTE_ALT: begin
            execute_enabled_next = 1'b1;
            res_wv               = ex_eff && cheat_active;
          end
          OP_WR_HALF, OP_WR_HALF_ALT: begin
            execute_enabled_next = 1'b1;
            res_wv               = ex_eff && cheat_active;
            res_half             = 1'b1;
          end
          OP_BTN_BYTE: begin
            execute_enabled_next = 1'b1;
            res_wv               = ex_eff && cheat_active && button_pressed;
          end
          OP_BTN_HALF: begin
            execute_enabled_next = 1'b1;
            res_wv               = ex_eff && cheat_active && button_pressed;
            res_half             = 1'b1;
          end
          OP_EQ_BYTE: begin
            if (ex_eff) execute_enabled_next = (memory_value[7:0] == operand_value[7:0]);
          end
          OP_EQ_HALF: begin
            if (ex_eff) execute_enabled_next = (memory_value == operand_value);
          end
          OP_NE_BYTE: begin
            if (ex_eff) execute_enabled_next = (memory_value[7:0] != operand_value[7:0]);
          end
          OP_NE_HALF: begin
            if (ex_eff) execute_enabled_next = (memory_value != operand_value);
          end
          OP_SERIAL: begin
            serial_pending_next = 1'b1;
            run_len_next        = (hdr_count > 8'(MAX_SERIAL_WRITES)) ?
                                  CNT_W'(MAX_SERIAL_WRITES) : CNT_W'(hdr_count);
            addr_step_next      = addr_m[STEP_W-1:0];
            value_step_next     = operand_value;
          end
          default: begin
            res_illegal         = 1'b1;
            cheat_rejected_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Hold cheat state
  always_ff @(posedge clk) begin
    if (rst) begin
      execute_enabled <= 1'b1;
      serial_pending  <= 1'b0;
      run_len         <= '0;
      addr_step       <= '0;
      value_step      <= '0;
      cheat_rejected  <= 1'b0;
    end else begin
      execute_enabled <= execute_enabled_next;
      serial_pending  <= serial_pending_next;
      run_len         <= run_len_next;
      addr_step       <= addr_step_next;
      value_step      <= value_step_next;
      cheat_rejected  <= cheat_rejected_next;
    end
  end

  // Load the run at its start, advance it by one step per emitted write
  always_ff @(posedge clk) begin
    if (cmd.accept && status.run_go) begin
      run_addr <= {1'b0, addr_m} + (skip_first ? WADR_W'(addr_step) : '0);
      run_data <= operand_value[7:0] + (skip_first ? value_step[7:0] : 8'h00);
      run_idx  <= skip_first ? CNT_W'(1) : '0;
    end else if (cmd.run_step) begin
      run_addr <= run_addr + WADR_W'(addr_step);
      run_data <= run_data + value_step[7:0];
      run_idx  <= run_idx + CNT_W'(1);
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !status.run_go) || cmd.run_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.run_step) begin
      write_valid    <= 1'b1;
      write_address  <= run_addr;
      write_data     <= {8'h00, run_data};
      write_halfword <= 1'b0;
      illegal_code   <= 1'b0;
      last_result    <= status.run_last;
    end else if (cmd.accept && !status.run_go) begin
      write_valid    <= res_wv;
      write_address  <= res_wv ? {1'b0, addr_m} : '0;
      write_data     <= !res_wv ? '0 :
                        (res_half ? operand_value : {8'h00, operand_value[7:0]});
      write_halfword <= res_wv && res_half;
      illegal_code   <= res_illegal;
      last_result    <= 1'b1;
    end
  end

endmodule

>>> rtl/cheat_code_interpreter_core.sv
// ----------------------------------------------------------------------------
// cheat_code_interpreter_core
// Runs decoded cheat code lines and emits the memory writes they cause.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | first_in_cheat .. button_pressed (one line)
//  out     | out_valid/out_stall| write_valid .. last_result (one result)
//
//  An ordinary line gives one result.
//  A serial body line is expanded into its writes, one result each, by the
//  address and data step adders of the run counters.
//  Reset (rst, synchronous) returns the cheat state to its initial values.
//  A stalled output holds its result; in_stall stays high while it is full
//  and stalled, and during a serial run.
// ----------------------------------------------------------------------------
module cheat_code_interpreter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        first_in_cheat,
  input  logic                        cheat_active,
  input  logic [cci_pkg::OPC_W-1:0]   opcode,
  input  logic [cci_pkg::ADDR_W-1:0]  target_address,
  input  logic [cci_pkg::DATA_W-1:0]  operand_value,
  input  logic [cci_pkg::DATA_W-1:0]  memory_value,
  input  logic                        button_pressed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        write_valid,
  output logic [cci_pkg::WADR_W-1:0]  write_address,
  output logic [cci_pkg::DATA_W-1:0]  write_data,
  output logic                        write_halfword,
  output logic                        illegal_code,
  output logic                        last_result
);
  import cci_pkg::*;

  cci_cmd_t    cmd;
  cci_status_t status;

  // Sequencer
  cci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath and output register
  cci_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .first_in_cheat (first_in_cheat),
    .cheat_active   (cheat_active),
    .opcode         (opcode),
    .target_address (target_address),
    .operand_value  (operand_value),
    .memory_value   (memory_value),
    .button_pressed (button_pressed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_valid    (write_valid),
    .write_address  (write_address),
    .write_data     (write_data),
    .write_halfword (write_halfword),
    .illegal_code   (illegal_code),
    .last_result    (last_result)
  );

endmodule

>>> rtl/cci_checker.sv
// ----------------------------------------------------------------------------
// cci_checker
// Port-level checks on the cheat code interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module cci_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        write_valid,
  input logic [cci_pkg::WADR_W-1:0]  write_address,
  input logic [cci_pkg::DATA_W-1:0]  write_data,
  input logic                        write_halfword,
  input logic                        illegal_code,
  input logic                        last_result
);
  import cci_pkg::*;

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_address) &&
                               $stable(write_data) && $stable(last_result))
    else $error("stalled result changed");

  // A full, stalled output blocks new requests
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while output blocked");

  // A result without a write carries zero payload
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> write_address == '0 && write_data == '0 &&
                                  !write_halfword)
    else $error("empty result carries payload");

  // An illegal line gives a single, writeless, final result
  a_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal_code |-> !write_valid && last_result)
    else $error("illegal result malformed");

  // A byte write leaves the upper data byte clear
  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid && !write_halfword |-> write_data[15:8] == 8'h00)
    else $error("byte write with upper data");

endmodule

bind cheat_code_interpreter_core cci_checker u_cci_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .write_valid    (write_valid),
  .write_address  (write_address),
  .write_data     (write_data),
  .write_halfword (write_halfword),
  .illegal_code   (illegal_code),
  .last_result    (last_result)
);

>>> bench/cheat_code_interpreter_core_test.sv
// ----------------------------------------------------------------------------
// cheat_code_interpreter_core_test
// Self-checking bench for the cheat code interpreter. A short table of code
// lines covers every opcode, the field extremes, skipping, muting and serial
// runs. Cheats built at random follow. Every result that the block returns is
// compared field by field against a predictor of the cheat state.
// ----------------------------------------------------------------------------
module cheat_code_interpreter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cci_pkg::*;

  localparam int RANDOM_LINES = 134;
  localparam int HOLD_OFF     = 300;
  localparam int DRAIN_CYCLES = 16;

  // Opcodes that the block does not know
  localparam logic [OPC_W-1:0] OP_BAD_LOW  = 8'h00;
  localparam logic [OPC_W-1:0] OP_BAD_HIGH = 8'hFF;

  localparam logic [OPC_W-1:0] WRITE_OPS [6] = '{OP_WR_BYTE, OP_WR_BYTE_ALT, OP_WR_HALF,
                                                 OP_WR_HALF_ALT, OP_BTN_BYTE, OP_BTN_HALF};
  localparam logic [OPC_W-1:0] COND_OPS [4]  = '{OP_EQ_BYTE, OP_EQ_HALF, OP_NE_BYTE, OP_NE_HALF};

  typedef struct packed {
    logic              write_valid;
    logic [WADR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              write_halfword;
    logic              illegal_code;
    logic              last_result;
  } write_result_t;

  typedef struct packed {
    logic              first;
    logic              active;
    logic [OPC_W-1:0]  opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] mem;
    logic              button;
    logic              known;
    write_result_t     typed;
  } code_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              first_in_cheat;
  logic              cheat_active;
  logic [OPC_W-1:0]  opcode;
  logic [ADDR_W-1:0] target_address;
  logic [DATA_W-1:0] operand_value;
  logic [DATA_W-1:0] memory_value;
  logic              button_pressed;
  logic              out_valid;
  logic              out_stall;
  logic              write_valid;
  logic [WADR_W-1:0] write_address;
  logic [DATA_W-1:0] write_data;
  logic              write_halfword;
  logic              illegal_code;
  logic              last_result;

  // Predicted cheat state
  logic              exec_on;
  logic              serial_armed;
  logic [CNT_W-1:0]  armed_len;
  logic [STEP_W-1:0] serial_astep;
  logic [DATA_W-1:0] serial_vstep;
  logic              cheat_muted;

  write_result_t pending_results[$];
  code_row_t     directed[$];

  int err_count;
  int lines_sent;
  int results_checked;
  int writes_seen;
  int illegal_seen;
  int serial_runs;
  int tx_calm;
  int rx_calm;
  bit pressure_done;

  cheat_code_interpreter_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One write instruction under the skip rule: a pending skip eats it
  function bit take_write();
    if (exec_on) return 1'b1;
    exec_on = 1'b1;
    return 1'b0;
  endfunction

  function automatic write_result_t make_write(logic [WADR_W-1:0] wa, logic [DATA_W-1:0] wd,
                                               logic half);
    write_result_t r;
    r = '0;
    r.write_valid    = 1'b1;
    r.write_address  = wa;
    r.write_data     = half ? wd : {8'h00, wd[7:0]};
    r.write_halfword = half;
    return r;
  endfunction

  function automatic void run_code_line(code_row_t ln, ref write_result_t batch[$]);
    logic [ADDR_W-1:0] a;
    logic              bad;
    write_result_t     idle_r;
    a   = ln.address & ADDR_MASK;
    bad = 1'b0;
    batch.delete();
    if (ln.first) begin
      exec_on      = 1'b1;
      serial_armed = 1'b0;
      cheat_muted  = 1'b0;
    end
    if (cheat_muted) begin
      // muted until the next cheat starts
    end else if (serial_armed) begin
      // expand the line into a run of byte writes
      serial_armed = 1'b0;
      if (armed_len != 0) serial_runs++;
      for (int i = 0; i < armed_len; i++) begin
        if (take_write() && ln.active)
          batch.push_back(make_write(WADR_W'(a + serial_astep * i),
                                     {8'h00, 8'(ln.value + serial_vstep * i)}, 1'b0));
      end
    end else begin
      case (ln.opcode)
        OP_WR_BYTE, OP_WR_BYTE_ALT:
          if (take_write() && ln.active) batch.push_back(make_write({1'b0, a}, ln.value, 1'b0));
        OP_WR_HALF, OP_WR_HALF_ALT:
          if (take_write() && ln.active) batch.push_back(make_write({1'b0, a}, ln.value, 1'b1));
        OP_BTN_BYTE:
          if (take_write() && ln.active && ln.button)
            batch.push_back(make_write({1'b0, a}, ln.value, 1'b0));
        OP_BTN_HALF:
          if (take_write() && ln.active && ln.button)
            batch.push_back(make_write({1'b0, a}, ln.value, 1'b1));
        OP_EQ_BYTE: if (exec_on) exec_on = (ln.mem[7:0] == ln.value[7:0]);
        OP_EQ_HALF: if (exec_on) exec_on = (ln.mem == ln.value);
        OP_NE_BYTE: if (exec_on) exec_on = (ln.mem[7:0] != ln.value[7:0]);
        OP_NE_HALF: if (exec_on) exec_on = (ln.mem != ln.value);
        OP_SERIAL: begin
          serial_armed = 1'b1;
          armed_len    = (a[15:8] > MAX_SERIAL_WRITES) ? CNT_W'(MAX_SERIAL_WRITES)
                                                       : CNT_W'(a[15:8]);
          serial_astep = a[7:0];
          serial_vstep = ln.value;
        end
        default: begin
          bad         = 1'b1;
          cheat_muted = 1'b1;
        end
      endcase
    end
    if (batch.size() == 0) begin
      idle_r = '0;
      idle_r.illegal_code = bad;
      batch.push_back(idle_r);
    end
    batch[batch.size()-1].last_result = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic code_row_t plain_row(logic f, logic act, logic [OPC_W-1:0] op,
                                          logic [ADDR_W-1:0] ad, logic [DATA_W-1:0] v,
                                          logic [DATA_W-1:0] m, logic b);
    code_row_t r;
    r = '0;
    r.first   = f;
    r.active  = act;
    r.opcode  = op;
    r.address = ad;
    r.value   = v;
    r.mem     = m;
    r.button  = b;
    return r;
  endfunction

  // Row whose single result is written out by hand
  function automatic code_row_t known_row(code_row_t r, logic wv, logic [WADR_W-1:0] wa,
                                          logic [DATA_W-1:0] wd, logic wh, logic ill);
    r.known                = 1'b1;
    r.typed.write_valid    = wv;
    r.typed.write_address  = wa;
    r.typed.write_data     = wd;
    r.typed.write_halfword = wh;
    r.typed.illegal_code   = ill;
    r.typed.last_result    = 1'b1;
    return r;
  endfunction

  function automatic bit is_code_op(logic [OPC_W-1:0] op);
    case (op)
      OP_WR_BYTE, OP_WR_BYTE_ALT, OP_WR_HALF, OP_WR_HALF_ALT, OP_BTN_BYTE, OP_BTN_HALF,
      OP_EQ_BYTE, OP_EQ_HALF, OP_NE_BYTE, OP_NE_HALF, OP_SERIAL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(10, 30);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Predict, then offer the request and hold it until it is taken
  task automatic send_line(code_row_t ln);
    write_result_t batch[$];
    int            gap;
    run_code_line(ln, batch);
    if (ln.known) begin
      batch.delete();
      batch.push_back(ln.typed);
    end
    foreach (batch[i]) pending_results.push_back(batch[i]);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_in_cheat <= ln.first;
    cheat_active   <= ln.active;
    opcode         <= ln.opcode;
    target_address <= ln.address;
    operand_value  <= ln.value;
    memory_value   <= ln.mem;
    button_pressed <= ln.button;
    do @(posedge clk); while (in_stall);
    lines_sent++;
  endtask

  // A random cheat: mostly well-formed lines, some illegal codes and noise
  task automatic send_random_cheat();
    code_row_t ln;
    int        n_lines;
    int        kind;
    n_lines = $urandom_range(1, 6);
    for (int k = 0; k < n_lines; k++) begin
      ln = plain_row(k == 0, $urandom_range(0, 9) != 0, 8'($urandom), 24'($urandom),
                     16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        ln.opcode = WRITE_OPS[$urandom_range(0, 5)];
      end else if (kind < 60) begin
        ln.opcode = COND_OPS[$urandom_range(0, 3)];
        case ($urandom_range(0, 2))
          0: ln.mem = ln.value;
          1: ln.mem = {8'($urandom), ln.value[7:0]};
          default: ;
        endcase
      end else if (kind < 80) begin
        // header, then a body line of any opcode
        ln.opcode = OP_SERIAL;
        ln.address[15:8] = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 8))
                                                       : 8'($urandom_range(0, 255));
        send_line(ln);
        ln = plain_row($urandom_range(0, 11) == 0, $urandom_range(0, 9) != 0, 8'($urandom),
                       24'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom_range(0, 1)));
      end else if (kind < 85) begin
        while (is_code_op(ln.opcode)) ln.opcode = 8'($urandom);
      end else if (kind < 90) begin
        ln.first = 1'($urandom_range(0, 1));
      end else begin
        ln.opcode = WRITE_OPS[$urandom_range(0, 5)];
        ln.first  = $urandom_range(0, 3) == 0;
      end
      send_line(ln);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    write_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: valid %0b addr 0x%0h data 0x%0h",
               write_valid, write_address, write_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("write_valid",    32'(want.write_valid),    32'(write_valid));
        check_field("write_address",  32'(want.write_address),  32'(write_address));
        check_field("write_data",     32'(want.write_data),     32'(write_data));
        check_field("write_halfword", 32'(want.write_halfword), 32'(write_halfword));
        check_field("illegal_code",   32'(want.illegal_code),   32'(illegal_code));
        check_field("last_result",    32'(want.last_result),    32'(last_result));
        results_checked++;
        if (write_valid) writes_seen++;
        if (illegal_code) illegal_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off while requests keep coming
  // --------------------------------------------------------------------------
  initial begin
    int g;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = pick_gap(rx_calm);
      if (!pressure_done && lines_sent >= directed.size() + 40) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    first_in_cheat <= 1'b0;
    cheat_active   <= 1'b0;
    opcode         <= '0;
    target_address <= '0;
    operand_value  <= '0;
    memory_value   <= '0;
    button_pressed <= 1'b0;

    exec_on      = 1'b1;
    serial_armed = 1'b0;
    armed_len    = '0;
    serial_astep = '0;
    serial_vstep = '0;
    cheat_muted  = 1'b0;

    directed = '{
      // plain writes straight after reset, at the field extremes
      known_row(plain_row(1, 1, OP_WR_BYTE, 24'hFFFFFF, 16'hFFFF, 16'h0000, 0),
                1, 25'h0FFFFFF, 16'h00FF, 0, 0),
      known_row(plain_row(0, 1, OP_WR_BYTE_ALT, 24'h000000, 16'h0000, 16'hFFFF, 1),
                1, 25'h0000000, 16'h0000, 0, 0),
      known_row(plain_row(0, 1, OP_WR_HALF, 24'h123456, 16'hBEEF, 16'h0000, 0),
                1, 25'h0123456, 16'hBEEF, 1, 0),
      known_row(plain_row(0, 1, OP_WR_HALF_ALT, 24'hABCDEF, 16'h8001, 16'h0000, 0),
                1, 25'h0ABCDEF, 16'h8001, 1, 0),
      // button gated writes
      known_row(plain_row(0, 1, OP_BTN_BYTE, 24'h000100, 16'h1234, 16'h0000, 0),
                0, 25'h0, 16'h0, 0, 0),
      known_row(plain_row(0, 1, OP_BTN_HALF, 24'h800000, 16'h5678, 16'h0000, 1),
                1, 25'h0800000, 16'h5678, 1, 0),
      // inactive cheat gives nothing
      known_row(plain_row(0, 0, OP_WR_HALF, 24'h00FF00, 16'hFFFF, 16'h0000, 1),
                0, 25'h0, 16'h0, 0, 0),
      // illegal code flags, then mutes the rest of the cheat
      known_row(plain_row(0, 1, OP_BAD_LOW, 24'h000200, 16'h0001, 16'h0000, 0),
                0, 25'h0, 16'h0, 0, 1),
      known_row(plain_row(0, 1, OP_WR_BYTE, 24'h000300, 16'h00AA, 16'h0000, 0),
                0, 25'h0, 16'h0, 0, 0),
      known_row(plain_row(1, 0, OP_BAD_HIGH, 24'h000400, 16'h0002, 16'h0000, 0),
                0, 25'h0, 16'h0, 0, 1),
      // conditionals and skipping
      plain_row(1, 1, OP_EQ_BYTE, 24'h000010, 16'h3412, 16'hAB12, 0),
      plain_row(0, 1, OP_WR_BYTE, 24'h000011, 16'h0077, 16'h0000, 0),
      plain_row(0, 1, OP_EQ_HALF, 24'h000020, 16'h1234, 16'h1235, 0),
      plain_row(0, 1, OP_NE_BYTE, 24'h000021, 16'h00AA, 16'h00BB, 0),
      plain_row(0, 1, OP_WR_HALF, 24'h000022, 16'hDEAD, 16'h0000, 0),
      plain_row(0, 1, OP_NE_HALF, 24'h000024, 16'h1234, 16'h1234, 0),
      plain_row(0, 1, OP_BTN_HALF, 24'h000025, 16'h1111, 16'h0000, 0),
      // saturated serial run with the largest steps and an address carry into bit 24
      plain_row(1, 1, OP_SERIAL, 24'h00FFFF, 16'hFFFF, 16'h0000, 0),
      plain_row(0, 1, OP_WR_BYTE, 24'hFFFFFF, 16'h00FF, 16'h0000, 0),
      // pending skip drops only the first write of a run
      plain_row(0, 1, OP_EQ_BYTE, 24'h000030, 16'h0001, 16'h0002, 0),
      plain_row(0, 1, OP_SERIAL, 24'h000302, 16'h0005, 16'h0000, 0),
      plain_row(0, 1, OP_BAD_HIGH, 24'h001000, 16'h00FE, 16'h0000, 1),
      // empty run leaves the skip in place
      plain_row(0, 1, OP_NE_HALF, 24'h000040, 16'h0001, 16'h0001, 0),
      plain_row(0, 1, OP_SERIAL, 24'h0000FF, 16'h0001, 16'h0000, 0),
      plain_row(0, 1, OP_WR_HALF, 24'h000041, 16'h4444, 16'h0000, 0),
      plain_row(0, 1, OP_WR_BYTE, 24'h000042, 16'h0055, 16'h0000, 0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_line(directed[i]);
    while (lines_sent < directed.size() + RANDOM_LINES) send_random_cheat();
    in_valid <= 1'b0;

    // drain, then allow for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d code lines; checked %0d results (%0d writes, %0d illegal flags).",
             lines_sent, results_checked, writes_seen, illegal_seen);
    $display("Covered every opcode, skips, muted cheats and %0d serial runs.", serial_runs);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
